// ----- rtl/core/sprite_scanline_evaluator_macros.svh -----
// Assertion macros shared by the sprite scanline evaluator checkers
`ifndef SPRITE_SCANLINE_EVALUATOR_MACROS_SVH
`define SPRITE_SCANLINE_EVALUATOR_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define SSEV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sprite evaluator assertion failed");

// Clocked assertion that also holds during reset
`define SSEV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sprite evaluator assertion failed");

`endif

// ----- rtl/core/ssev_pkg.sv -----
// Shared types and constants for the sprite scanline evaluator
package ssev_pkg;

    localparam int NUM_SPRITES  = 64;
    localparam int MAX_PER_LINE = 8;

    localparam int SLOT_W   = 6;
    localparam int NUM_WORDS = 64;
    localparam int ISSUE_W  = $clog2(NUM_SPRITES + 1);
    localparam int FOUND_W  = $clog2(MAX_PER_LINE + 1);

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    // Classified command passed from front to back
    typedef struct packed
    {
        op_t               op;
        logic [7:0]        addr;
        logic [7:0]        data;
        logic signed [9:0] line_m1;
        logic              tall;
    } cmd_t;

    // Front queue status seen by the back
    typedef struct packed
    {
        logic valid;
        cmd_t cmd;
    } cmdq_head_t;

    typedef struct packed
    {
        logic       hit;
        logic [5:0] slot;
        logic [7:0] sprite_y;
        logic [7:0] tile;
        logic       flip_v;
        logic       flip_h;
        logic       behind_bg;
        logic [1:0] palette;
        logic [7:0] sprite_x;
        logic       is_zero;
        logic       last;
    } res_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } scan_state_t;

endpackage

// ----- rtl/core/ssev_front.sv -----
// Input side: accepts items, classifies them and queues commands
module ssev_front
    import ssev_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       cmd,
    input  logic [7:0] oam_addr,
    input  logic [7:0] oam_data,
    input  logic [8:0] scanline,
    input  logic       tall_sprites,
    output cmdq_head_t head,
    input  logic       head_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    cmd_t       cmd_dec;
    logic       do_push;
    logic       do_pop;

    // Decode the raw item; the window top is scanline - 1
    always_comb
    begin
        cmd_dec.op      = cmd ? OP_EVAL : OP_WRITE;
        cmd_dec.addr    = oam_addr;
        cmd_dec.data    = oam_data;
        cmd_dec.line_m1 = $signed({1'b0, scanline}) - 10'sd1;
        cmd_dec.tall    = tall_sprites;
    end

    assign full     = (count_reg == 2'd2);
    assign do_push  = push && !full;
    assign do_pop   = head_pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cmd_dec;
        end
    end

endmodule

// ----- rtl/core/ssev_back.sv -----
// Execution side: attribute memory, write handling and scanline scan
module ssev_back
    import ssev_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmdq_head_t head,
    output logic       head_pop,
    input  logic       res_full,
    output logic       res_push,
    output res_t       res_data
);

    logic [3:0][7:0]    mem [NUM_WORDS];
    scan_state_t        state_reg;
    scan_state_t        state_next;
    logic [ISSUE_W-1:0] issue_reg;
    logic [ISSUE_W-1:0] issue_next;
    logic               rd_valid_reg;
    logic               rd_valid_next;
    logic [FOUND_W-1:0] found_reg;
    logic [FOUND_W-1:0] found_next;
    logic [FOUND_W-1:0] found_inc;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [31:0]        pend_word_reg;
    logic [31:0]        pend_word_next;
    logic [SLOT_W-1:0]  pend_slot_reg;
    logic [SLOT_W-1:0]  pend_slot_next;
    logic signed [9:0]  line_reg;
    logic signed [9:0]  line_next;
    logic               tall_reg;
    logic               tall_next;
    logic [31:0]        rd_word_reg;
    logic [SLOT_W-1:0]  rd_slot_reg;
    logic               rd_en;
    logic               wr_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic signed [10:0] diff;
    logic               row_hit;

    function automatic res_t make_result(logic [31:0] word, logic [SLOT_W-1:0] slot,
                                         logic last);
        res_t r;
        r.hit       = 1'b1;
        r.slot      = slot;
        r.sprite_y  = word[7:0];
        r.tile      = word[15:8];
        r.flip_v    = word[23];
        r.flip_h    = word[22];
        r.behind_bg = word[21];
        r.palette   = word[17:16];
        r.sprite_x  = word[31:24];
        r.is_zero   = (slot == '0);
        r.last      = last;
        return r;
    endfunction

    assign rd_addr   = SLOT_W'(issue_reg);
    assign found_inc = found_reg + FOUND_W'(1);

    // Window test: 0 <= (scanline - 1 - y) < height
    assign diff    = 11'(line_reg) - $signed({3'b000, rd_word_reg[7:0]});
    assign row_hit = !diff[10] && (diff[9:4] == 6'd0) && (tall_reg || !diff[3]);

    // Attribute memory: byte writes, registered word read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[head.cmd.addr[7:2]][head.cmd.addr[1:0]] <= head.cmd.data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
            rd_slot_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            rd_valid_reg   <= rd_valid_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_word_reg <= pend_word_next;
        pend_slot_reg <= pend_slot_next;
        line_reg      <= line_next;
        tall_reg      <= tall_next;
    end

    // Sequencer: command dispatch, scan pipeline, final flush
    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        rd_valid_next   = rd_valid_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        pend_slot_next  = pend_slot_reg;
        line_next       = line_reg;
        tall_next       = tall_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        head_pop        = 1'b0;
        res_push        = 1'b0;
        res_data        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    head_pop = 1'b1;
                    if (head.cmd.op == OP_WRITE)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        line_next       = head.cmd.line_m1;
                        tall_next       = head.cmd.tall;
                        issue_next      = '0;
                        rd_valid_next   = 1'b0;
                        found_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Whole pipeline holds while the result queue is full
                if (!res_full)
                begin
                    rd_valid_next = 1'b0;
                    if (issue_reg != ISSUE_W'(NUM_SPRITES))
                    begin
                        rd_en         = 1'b1;
                        rd_valid_next = 1'b1;
                        issue_next    = issue_reg + ISSUE_W'(1);
                    end
                    if (rd_valid_reg && row_hit)
                    begin
                        // Previous hit is not the last one; send it now
                        if (pend_valid_reg)
                        begin
                            res_push = 1'b1;
                            res_data = make_result(pend_word_reg, pend_slot_reg, 1'b0);
                        end
                        pend_valid_next = 1'b1;
                        pend_word_next  = rd_word_reg;
                        pend_slot_next  = rd_slot_reg;
                        found_next      = found_inc;
                        if (found_inc == FOUND_W'(MAX_PER_LINE))
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else if ((issue_reg == ISSUE_W'(NUM_SPRITES)) && !rd_valid_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_data = make_result(pend_word_reg, pend_slot_reg, 1'b1);
                    end
                    else
                    begin
                        res_data.last = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ssev_outq.sv -----
// Two-entry result queue driving the output side
module ssev_outq
    import ssev_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    input  res_t res_data,
    output logic res_full,
    input  logic pop,
    output logic empty,
    output res_t head
);

    res_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;
    assign head     = q_reg[rd_ptr_reg];

    assign count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ do_push;
            rd_ptr_reg <= rd_ptr_reg ^ do_pop;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res_data;
        end
    end

endmodule

// ----- rtl/core/sprite_scanline_evaluator.sv -----
// Sprite scanline evaluator top level
// A write item (cmd = 0) stores one attribute byte in the execution unit; an
// evaluate item (cmd = 1) walks all 64 sprite entries, one 32-bit attribute
// word read per cycle from the single-port attribute memory while the result
// queue is not full, and passes through dispatch, 64 reads, the compare of the
// last read, a step that sees the read pipeline empty and the final flush; the
// eighth hit ends the scan early.
// Up to 8 results per scanline come out in slot order with last on the final
// one; a scanline with no sprite gives one result with hit = 0 and last = 1.
// A two-entry command queue sits in front of the unit and a two-entry result
// queue behind it. Attribute memory is not cleared at reset; evaluating
// sprites that were never written returns undefined fields.
module sprite_scanline_evaluator
    import ssev_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       cmd,
    input  logic [7:0] oam_addr,
    input  logic [7:0] oam_data,
    input  logic [8:0] scanline,
    input  logic       tall_sprites,
    output logic       empty,
    input  logic       pop,
    output logic       hit,
    output logic [5:0] slot,
    output logic [7:0] sprite_y,
    output logic [7:0] tile,
    output logic       flip_v,
    output logic       flip_h,
    output logic       behind_bg,
    output logic [1:0] palette,
    output logic [7:0] sprite_x,
    output logic       is_zero,
    output logic       last
);

    cmdq_head_t cmd_head;
    logic       cmd_pop;
    logic       res_full;
    logic       res_push;
    res_t       res_data;
    res_t       out_head;

    ssev_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .oam_addr     (oam_addr),
        .oam_data     (oam_data),
        .scanline     (scanline),
        .tall_sprites (tall_sprites),
        .head         (cmd_head),
        .head_pop     (cmd_pop)
    );

    ssev_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (cmd_head),
        .head_pop (cmd_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_data)
    );

    ssev_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .head     (out_head)
    );

    // Unpack the oldest result onto the ports
    assign hit       = out_head.hit;
    assign slot      = out_head.slot;
    assign sprite_y  = out_head.sprite_y;
    assign tile      = out_head.tile;
    assign flip_v    = out_head.flip_v;
    assign flip_h    = out_head.flip_h;
    assign behind_bg = out_head.behind_bg;
    assign palette   = out_head.palette;
    assign sprite_x  = out_head.sprite_x;
    assign is_zero   = out_head.is_zero;
    assign last      = out_head.last;

endmodule

// ----- rtl/core/ssev_checker.sv -----
// Port-level checker for the sprite scanline evaluator, bound to the top
`include "sprite_scanline_evaluator_macros.svh"

module ssev_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       hit,
    input logic [5:0] slot,
    input logic [7:0] sprite_x,
    input logic       is_zero,
    input logic       last
);

    // A waiting result holds until it is taken
    `SSEV_ASSERT(a_res_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(slot) && $stable(hit) && $stable(last) && $stable(sprite_x)))

    // A no-hit result closes its evaluation and carries zero fields
    `SSEV_ASSERT(a_nohit_last, clk, rst_n, (!empty && !hit) |-> (last && slot == 6'd0 && !is_zero && sprite_x == 8'd0))

    // Sprite-zero mark matches the slot
    `SSEV_ASSERT(a_zero_mark, clk, rst_n, (!empty && hit) |-> (is_zero == (slot == 6'd0)))

    // Within one evaluation, slots rise strictly
    `SSEV_ASSERT(a_slot_order, clk, rst_n, (!empty && pop && hit && !last) ##1 (!empty) |-> (hit && slot > $past(slot)))

    // Nothing waits on the output while reset is held
    `SSEV_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> empty)

endmodule

bind sprite_scanline_evaluator ssev_checker u_ssev_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .hit      (hit),
    .slot     (slot),
    .sprite_x (sprite_x),
    .is_zero  (is_zero),
    .last     (last)
);
